// ===== sv/rhrt_pkg.sv =====
package rhrt_pkg;
    localparam int DEPTH = 16;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int HB = 32;

    localparam logic [2:0] CMD_BEGIN = 3'd0;
    localparam logic [2:0] CMD_END   = 3'd1;
    localparam logic [2:0] CMD_ERASE = 3'd2;
    localparam logic [2:0] CMD_REPL  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;
    localparam logic [2:0] CMD_WRITE = 3'd5;
    localparam logic [2:0] CMD_CLEAR = 3'd6;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_OFF  = 2'd1;
    localparam logic [1:0] ST_DIS  = 2'd2;

    localparam logic [0:0] REG_SIZE = 1'd0;
    localparam logic [0:0] REG_EN   = 1'd1;

    typedef struct packed {
        logic [HB-1:0] db;
        logic [HB-1:0] de;
        logic [HB-1:0] rb;
        logic [HB-1:0] re;
    } t_entry;
endpackage

// ===== sv/ring_history_range_table.sv =====
// Ring history of ranges: 16 entries of four 32-bit handles in one memory with
// a registered read. Every command returns exactly one result, strobed by
// o_valid for one cycle; the receiver cannot stall, so the block never waits.
// Begin reads and rewrites the new entry, then reads and patches the previous
// one; end reads then writes the entry, read range reads it and write range
// writes it. Replace record reads and writes every valid entry in turn. Erase
// runs a search pass of one read per valid entry, then a clearing pass of one
// read and one write per entry visited.
// busy is high from the cycle after start is accepted until the result cycle.
module ring_history_range_table
    import rhrt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_index,
    input  logic [4:0]    i_cfg_data,
    input  logic [2:0]    i_command,
    input  logic [HB-1:0] i_disp_begin,
    input  logic [HB-1:0] i_disp_end,
    input  logic [HB-1:0] i_rec_begin,
    input  logic [HB-1:0] i_rec_end,
    input  logic [HB-1:0] i_new_rec,
    input  logic [4:0]    i_offset,
    input  logic          i_delete_entries,
    output logic          o_valid,
    output logic [1:0]    o_status,
    output logic [HB-1:0] o_out_disp_begin,
    output logic [HB-1:0] o_out_disp_end,
    output logic [HB-1:0] o_out_rec_begin,
    output logic [HB-1:0] o_out_rec_end,
    output logic [4:0]    o_entry_count
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_WR   = 3'd2;
    localparam logic [2:0] S_SRCH = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]    r_state;
    logic [4:0]    r_size;
    logic          r_en;
    logic [CW-1:0] r_wp, r_cnt;
    logic [2:0]    r_cmd;
    logic [HB-1:0] r_db, r_de, r_rb, r_re, r_nr;
    logic          r_del;
    logic [CW-1:0] r_i, r_num;
    logic [AW-1:0] r_idx;
    logic          r_found;
    logic [1:0]    r_status;
    t_entry        r_out;
    logic          r_valid;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata, rdata;

    rhrt_ram u_ram (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic [CW-1:0] s_eff, cnt_c, wp_c, wpw;
    logic [CW:0]   ridx;
    always_comb begin
        s_eff = (r_size > 5'(DEPTH)) ? CW'(DEPTH) : CW'(r_size);
        cnt_c = (r_cnt > s_eff) ? s_eff : r_cnt;
        wp_c  = (r_wp > s_eff) ? s_eff : r_wp;
        wpw   = (wp_c >= s_eff) ? '0 : wp_c;
        ridx  = {1'b0, wp_c} - (CW+1)'(i_offset) - 1'b1;
        if (ridx[CW]) ridx = ridx + {1'b0, cnt_c};
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // memory access control
    logic [AW-1:0] prev_idx;
    always_comb begin
        we = 1'b0; waddr = r_idx; wdata = rdata;
        raddr = r_idx;
        prev_idx = (r_wp == '0) ? AW'(s_eff - 1'b1) : AW'(r_wp - 1'b1);
        if (r_state == S_WR) begin
            case (r_cmd)
                CMD_BEGIN: begin
                    // stage 0 writes the new entry begin, stage 1 patches prev
                    if (r_i == '0) begin
                        we = 1'b1; waddr = AW'(r_wp);
                        wdata.db = r_db; wdata.rb = r_rb;
                    end else begin
                        we = 1'b1; waddr = prev_idx;
                        if (rdata.de != '0) wdata.de = r_db;
                        if (rdata.re != '0) wdata.re = r_rb;
                    end
                end
                CMD_END: begin
                    we = 1'b1; waddr = AW'(r_wp);
                    wdata.de = r_de; wdata.re = r_re;
                end
                CMD_ERASE: begin
                    we = 1'b1;
                    wdata.db = '0; wdata.de = '0;
                end
                CMD_REPL: begin
                    we = 1'b1;
                    if (rdata.rb == r_rb) wdata.rb = r_nr;
                    if (rdata.re == r_rb) wdata.re = r_nr;
                end
                CMD_WRITE: begin
                    we = 1'b1;
                    wdata = '{db: r_db, de: r_de, rb: r_rb, re: r_re};
                end
                default: we = 1'b0;
            endcase
        end
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 5'd16;
            r_en   <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SIZE: r_size <= i_cfg_data;
                REG_EN:   r_en   <= i_cfg_data[0];
                default:  ;
            endcase
        end
    end

    // command sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (start) begin
                    r_cmd <= i_command; r_db <= i_disp_begin; r_de <= i_disp_end;
                    r_rb <= i_rec_begin; r_re <= i_rec_end; r_nr <= i_new_rec;
                    r_del <= i_delete_entries;
                    r_cnt <= cnt_c; r_wp <= wp_c;
                    r_status <= ST_DONE; r_out <= '0;
                    r_i <= '0; r_found <= 1'b0;
                    r_state <= S_DONE;
                    case (i_command)
                        CMD_BEGIN, CMD_END: if (!r_en || s_eff == '0) begin
                            r_status <= ST_DIS;
                        end else begin
                            // read the entry first so untouched handles survive
                            r_wp <= wpw;
                            r_idx <= AW'(wpw);
                            r_state <= S_RD;
                        end
                        CMD_ERASE: if (!r_en || s_eff == '0) begin
                            r_status <= ST_DIS;
                        end else if (cnt_c != '0) begin
                            r_idx <= '0;
                            r_state <= S_SRCH;
                        end
                        CMD_REPL: if (cnt_c != '0) begin
                            r_idx <= '0; r_state <= S_RD;
                        end
                        CMD_READ, CMD_WRITE: begin
                            if (CW'(i_offset) >= cnt_c || i_offset > 5'(DEPTH)
                                || ridx[CW] || ridx >= (CW+1)'(DEPTH)) begin
                                r_status <= ST_OFF;
                            end else begin
                                r_idx <= AW'(ridx);
                                r_state <= (i_command == CMD_READ) ? S_RD : S_WR;
                            end
                        end
                        CMD_CLEAR: begin
                            r_wp <= '0; r_cnt <= '0;
                        end
                        default: ;
                    endcase
                end
                S_SRCH: begin
                    // issue reads for 0..cnt-1, compare each once its registered data returns
                    if (r_i != '0 && rdata.db == r_db) r_found <= 1'b1;
                    if (r_i == r_cnt) begin
                        if ((r_found || rdata.db == r_db) || r_db == '0) begin
                            r_num <= r_cnt; r_i <= '0;
                            r_idx <= (r_db == '0) ? '0 :
                                     ((r_wp == '0) ? AW'(s_eff - 1'b1)
                                                   : AW'(r_wp - 1'b1));
                            r_state <= S_RD;
                        end else r_state <= S_DONE;
                    end else begin
                        r_i <= r_i + 1'b1;
                        if (r_i + 1'b1 != r_cnt) r_idx <= AW'(r_i + 1'b1);
                    end
                end
                S_RD: r_state <= S_WR;
                S_WR: begin
                    if (r_cmd == CMD_READ) r_out <= rdata;
                    case (r_cmd)
                        CMD_BEGIN: if (r_i == '0 && r_cnt != '0) begin
                            r_i <= CW'(1); r_idx <= prev_idx; r_state <= S_RD;
                        end else r_state <= S_DONE;
                        CMD_END: begin
                            r_wp <= r_wp + 1'b1;
                            if (r_cnt < s_eff) r_cnt <= r_cnt + 1'b1;
                            r_state <= S_DONE;
                        end
                        CMD_ERASE: if (r_db == '0) begin
                            if (r_i + 1'b1 == r_num) r_state <= S_DONE;
                            else begin
                                r_i <= r_i + 1'b1; r_idx <= AW'(r_i + 1'b1);
                                r_state <= S_RD;
                            end
                        end else begin
                            if (r_del) begin
                                r_cnt <= r_cnt - 1'b1;
                                r_wp <= (r_wp == '0) ? s_eff - 1'b1 : r_wp - 1'b1;
                            end
                            if (rdata.db == r_db || r_i + 1'b1 == r_num)
                                r_state <= S_DONE;
                            else begin
                                r_i <= r_i + 1'b1;
                                r_idx <= (r_idx == '0) ? AW'(r_num - 1'b1)
                                                       : r_idx - 1'b1;
                                r_state <= S_RD;
                            end
                        end
                        CMD_REPL: if (r_i + 1'b1 == r_cnt) r_state <= S_DONE;
                        else begin
                            r_i <= r_i + 1'b1; r_idx <= AW'(r_i + 1'b1);
                            r_state <= S_RD;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_out_disp_begin = r_out.db;
    assign o_out_disp_end   = r_out.de;
    assign o_out_rec_begin  = r_out.rb;
    assign o_out_rec_end    = r_out.re;
    assign o_entry_count    = 5'(r_cnt);

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("count over depth");
    a_onestrobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("double strobe");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");
endmodule

// ===== sv/rhrt_ram.sv =====
module rhrt_ram
    import rhrt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry       i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry       o_rdata
);
    t_entry mem [DEPTH];

    // write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== verif/tb_ring_history_range_table.sv =====
`timescale 1ns / 100ps

module tb_ring_history_range_table;
    import rhrt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [1:0]    status;
        t_entry        range;
        logic [4:0]    count;
    } t_result;

    // Shadow copy of the history table; predicts one result per command
    class history_scoreboard;
        t_entry  table_mem[DEPTH];
        int      wr_ptr;
        int      count;
        int      size_reg;
        bit      en_reg;
        t_result expected_q[$];
        int      errors;
        int      checked;

        function new();
            wr_ptr   = 0;
            count    = 0;
            size_reg = 16;
            en_reg   = 1;
            errors   = 0;
            checked  = 0;
            foreach (table_mem[i]) table_mem[i] = '0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 30) $display("ERROR @%0t: %s", $realtime, msg);
        endtask

        function void write_reg(logic [0:0] idx, logic [4:0] value);
            if (idx == REG_SIZE) size_reg = value;
            else en_reg = value[0];
        endfunction

        function int ring_size();
            return (size_reg > DEPTH) ? DEPTH : size_reg;
        endfunction

        // Walk back from the newest entry, clearing display handles up to the key
        function void erase_key(logic [HB-1:0] key, bit del, int s);
            bit found;
            int num, idx, p;
            bit hit;
            found = 0;
            p = wr_ptr;
            for (int i = 0; i < count; i++)
                if (table_mem[i].db == key) found = 1;
            if (!found) return;
            idx = wr_ptr - 1;
            if (idx < 0) idx = s - 1;
            num = count;
            for (int i = 0; i < num; i++) begin
                hit = (table_mem[idx].db == key);
                table_mem[idx].db = '0;
                table_mem[idx].de = '0;
                if (del) begin
                    count--;
                    p--;
                end
                if (hit) break;
                idx--;
                if (idx < 0) idx += num;
            end
            if (p < 0) p += s;
            wr_ptr = p;
        endfunction

        // Note an accepted item and queue the result it must produce
        function void note_item(logic [2:0] cmd, t_entry in_range, logic [HB-1:0] nr,
                                logic [4:0] off, bit del);
            t_result r;
            int s, idx;
            bit enabled;
            s = ring_size();
            enabled = en_reg && (s != 0);
            r.status = ST_DONE;
            r.range = '0;
            if (count > s) count = s;
            if (wr_ptr > s) wr_ptr = s;
            case (cmd)
                CMD_BEGIN: begin
                    if (!enabled) r.status = ST_DIS;
                    else begin
                        if (wr_ptr >= s) wr_ptr = 0;
                        table_mem[wr_ptr].db = in_range.db;
                        table_mem[wr_ptr].rb = in_range.rb;
                        if (count > 0) begin
                            idx = wr_ptr - 1;
                            if (idx < 0) idx = s - 1;
                            if (table_mem[idx].de != 0) table_mem[idx].de = in_range.db;
                            if (table_mem[idx].re != 0) table_mem[idx].re = in_range.rb;
                        end
                    end
                end
                CMD_END: begin
                    if (!enabled) r.status = ST_DIS;
                    else begin
                        if (wr_ptr >= s) wr_ptr = 0;
                        table_mem[wr_ptr].de = in_range.de;
                        table_mem[wr_ptr].re = in_range.re;
                        wr_ptr++;
                        if (count < s) count++;
                    end
                end
                CMD_ERASE: begin
                    if (!enabled) r.status = ST_DIS;
                    else if (in_range.db != 0) erase_key(in_range.db, del, s);
                    else
                        for (int i = 0; i < count; i++) begin
                            table_mem[i].db = '0;
                            table_mem[i].de = '0;
                        end
                end
                CMD_REPL: begin
                    for (int i = 0; i < count; i++) begin
                        if (table_mem[i].rb == in_range.rb) table_mem[i].rb = nr;
                        if (table_mem[i].re == in_range.rb) table_mem[i].re = nr;
                    end
                end
                CMD_READ, CMD_WRITE: begin
                    idx = wr_ptr - int'(off) - 1;
                    if (idx < 0) idx += count;
                    if (int'(off) >= count || idx < 0 || idx >= DEPTH) r.status = ST_OFF;
                    else if (cmd == CMD_READ) r.range = table_mem[idx];
                    else table_mem[idx] = in_range;
                end
                CMD_CLEAR: begin
                    wr_ptr = 0;
                    count = 0;
                end
                default: ;
            endcase
            r.count = count[4:0];
            expected_q.push_back(r);
        endfunction

        // Compare one strobed result with the oldest expectation
        task check_result(t_result got);
            t_result exp_r;
            checked++;
            if (expected_q.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.status !== exp_r.status)
                report($sformatf("status %0d, expected %0d", got.status, exp_r.status));
            if (got.range.db !== exp_r.range.db)
                report($sformatf("disp_begin %h, expected %h", got.range.db, exp_r.range.db));
            if (got.range.de !== exp_r.range.de)
                report($sformatf("disp_end %h, expected %h", got.range.de, exp_r.range.de));
            if (got.range.rb !== exp_r.range.rb)
                report($sformatf("rec_begin %h, expected %h", got.range.rb, exp_r.range.rb));
            if (got.range.re !== exp_r.range.re)
                report($sformatf("rec_end %h, expected %h", got.range.re, exp_r.range.re));
            if (got.count !== exp_r.count)
                report($sformatf("entry_count %0d, expected %0d", got.count, exp_r.count));
        endtask
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic          i_cfg_index;
    logic [4:0]    i_cfg_data;
    logic [2:0]    i_command;
    logic [HB-1:0] i_disp_begin;
    logic [HB-1:0] i_disp_end;
    logic [HB-1:0] i_rec_begin;
    logic [HB-1:0] i_rec_end;
    logic [HB-1:0] i_new_rec;
    logic [4:0]    i_offset;
    logic          i_delete_entries;
    logic          o_valid;
    logic [1:0]    o_status;
    logic [HB-1:0] o_out_disp_begin;
    logic [HB-1:0] o_out_disp_end;
    logic [HB-1:0] o_out_rec_begin;
    logic [HB-1:0] o_out_rec_end;
    logic [4:0]    o_entry_count;

    history_scoreboard sb;
    int cycles;
    int items_sent;
    int idle_pct;
    int cfg_writes;

    ring_history_range_table i_dut (.*);

    // Clock generation
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Guard against a hung handshake
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Check every strobed result
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid) begin
            got.status   = o_status;
            got.range.db = o_out_disp_begin;
            got.range.de = o_out_disp_end;
            got.range.rb = o_out_rec_begin;
            got.range.re = o_out_rec_end;
            got.count    = o_entry_count;
            sb.check_result(got);
        end
    end

    // Present one item and hold it until accepted, then idle at random
    task send_item(logic [2:0] cmd, logic [HB-1:0] db, logic [HB-1:0] de,
                   logic [HB-1:0] rb, logic [HB-1:0] re, logic [HB-1:0] nr,
                   logic [4:0] off, logic del);
        t_entry rng;
        rng = '{db: db, de: de, rb: rb, re: re};
        start            <= 1'b1;
        i_command        <= cmd;
        i_disp_begin     <= db;
        i_disp_end       <= de;
        i_rec_begin      <= rb;
        i_rec_end        <= re;
        i_new_rec        <= nr;
        i_offset         <= off;
        i_delete_entries <= del;
        do @(posedge i_clk); while (busy);
        sb.note_item(cmd, rng, nr, off, del);
        items_sent++;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Drop start, drain outstanding results, then write one register
    task write_reg(logic [0:0] idx, logic [4:0] value);
        start <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0 || busy);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, value);
        cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly small handles so erase and replace keys hit
    function logic [HB-1:0] pick_handle();
        case ($urandom_range(9))
            0:       return '0;
            1, 2, 3, 4, 5: return HB'($urandom_range(1, 6));
            6:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function logic [4:0] pick_offset();
        if (sb.count > 0 && $urandom_range(99) < 70)
            return 5'($urandom_range(0, sb.count - 1));
        return 5'($urandom_range(0, 16));
    endfunction

    task send_random();
        int pick;
        logic [2:0] cmd;
        pick = $urandom_range(99);
        if (pick < 55) begin
            // Well-formed begin then end pair
            send_item(CMD_BEGIN, pick_handle(), pick_handle(), pick_handle(), pick_handle(),
                      $urandom, pick_offset(), 1'($urandom));
            cmd = CMD_END;
        end else if (pick < 67) cmd = CMD_ERASE;
        else if (pick < 76) cmd = CMD_REPL;
        else if (pick < 87) cmd = CMD_READ;
        else if (pick < 94) cmd = CMD_WRITE;
        else if (pick < 96) cmd = CMD_CLEAR;
        else cmd = 3'($urandom_range(0, 1));
        send_item(cmd, pick_handle(), pick_handle(), pick_handle(), pick_handle(),
                  pick_handle(), pick_offset(), 1'($urandom));
    endtask

    initial begin
        int sizes[8];
        bit enables[8];
        int phase_end;
        sizes   = '{16, 1, 0, 5, 16, 7, 2, 16};
        enables = '{1, 1, 1, 1, 0, 1, 1, 1};
        sb = new();
        items_sent = 0;
        cfg_writes = 0;
        idle_pct = 30;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        i_command = CMD_READ;
        i_disp_begin = '0;
        i_disp_end = '0;
        i_rec_begin = '0;
        i_rec_end = '0;
        i_new_rec = '0;
        i_offset = '0;
        i_delete_entries = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every entry so later reads never touch an unwritten slot
        for (int i = 0; i < DEPTH; i++) begin
            send_item(CMD_BEGIN, HB'(i + 1), '0, HB'(i + 1), '0, '0, '0, 1'b0);
            send_item(CMD_END, '0, HB'(i + 2), '0, HB'(i + 2), '0, '0, 1'b0);
        end

        // Directed corners: pointer wrap, offsets, replace of null, erase flavors
        send_item(CMD_BEGIN, '1, '0, '1, '0, '0, '0, 1'b0);
        send_item(CMD_END, '0, '1, '0, '1, '0, '0, 1'b0);
        send_item(CMD_READ, '0, '0, '0, '0, '0, 5'd0, 1'b0);
        send_item(CMD_READ, '0, '0, '0, '0, '0, 5'd15, 1'b0);
        send_item(CMD_READ, '0, '0, '0, '0, '0, 5'd16, 1'b0);
        send_item(CMD_WRITE, '1, '1, '1, '1, '0, 5'd3, 1'b0);
        send_item(CMD_WRITE, '0, '0, '0, '0, '0, 5'd16, 1'b0);
        send_item(CMD_READ, '0, '0, '0, '0, '0, 5'd3, 1'b0);
        send_item(CMD_REPL, '0, '0, HB'(5), '0, 32'hA5A5_5A5A, '0, 1'b0);
        send_item(CMD_REPL, '0, '0, '0, '0, 32'h5A5A_A5A5, '0, 1'b0);
        send_item(CMD_ERASE, 32'hDEAD_BEEF, '0, '0, '0, '0, '0, 1'b1);
        send_item(CMD_ERASE, HB'(14), '0, '0, '0, '0, '0, 1'b0);
        send_item(CMD_ERASE, HB'(9), '0, '0, '0, '0, '0, 1'b1);
        send_item(CMD_READ, '0, '0, '0, '0, '0, 5'd0, 1'b0);
        send_item(CMD_ERASE, '0, '0, '0, '0, '0, '0, 1'b1);
        send_item(CMD_READ, '0, '0, '0, '0, '0, 5'd1, 1'b0);
        send_item(CMD_CLEAR, '0, '0, '0, '0, '0, '0, 1'b0);
        send_item(CMD_READ, '0, '0, '0, '0, '0, 5'd0, 1'b0);
        send_item(CMD_BEGIN, HB'(7), '0, HB'(7), '0, '0, '0, 1'b0);
        send_item(CMD_END, '0, HB'(8), '0, HB'(8), '0, '0, 1'b0);

        // Random phases across register settings
        foreach (sizes[p]) begin
            write_reg(REG_SIZE, 5'(sizes[p]));
            write_reg(REG_EN, 5'(enables[p]));
            phase_end = items_sent + 150;
            while (items_sent < phase_end) begin
                idle_pct = (items_sent < 450) ? 30 : (items_sent < 850) ? 73 : 0;
                send_random();
            end
        end

        start <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0);
        repeat (40) @(posedge i_clk);
        $display("covered %0d commands, %0d results checked, %0d register writes",
                 items_sent, sb.checked, cfg_writes);
        $display("sizes 0 to 16 with history on and off, sender gaps 30%%, 73%% and none");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_q.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
